### hw/rtl/vrt_pkg.sv
// ---------------------------------------------------------------------------
// vrt_pkg
// Types, codes and constants shared by the voxel ray traversal modules.
// ---------------------------------------------------------------------------
package vrt_pkg;

    localparam int unsigned WORLD_HEIGHT_DEF = 128;
    localparam int unsigned DIV_BITS         = 31;
    localparam logic [31:0] SAT32            = 32'hFFFF_FFFF;

    // Result kinds.
    localparam logic [1:0] RK_QUERY = 2'd0;
    localparam logic [1:0] RK_HIT   = 2'd1;
    localparam logic [1:0] RK_MAXD  = 2'd2;
    localparam logic [1:0] RK_EXIT  = 2'd3;

    // Input kinds.
    localparam logic IK_START  = 1'b0;
    localparam logic IK_ANSWER = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [31:0]        max_distance;
        logic               voxel_present;
        logic               voxel_solid;
    } item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [15:0] voxel_x;
        logic signed [15:0] voxel_y;
        logic signed [15:0] voxel_z;
        logic [31:0]        hit_distance;
        logic [1:0]         normal_axis;
        logic               normal_negative;
        logic signed [31:0] impact_x;
        logic signed [31:0] impact_y;
        logic signed [31:0] impact_z;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CROSS,
        S_CHECK,
        S_IMUL,
        S_IADD,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_REJECT,
        RES_QUERY,
        RES_HIT,
        RES_MAXD
    } res_sel_t;

    typedef struct packed {
        logic       load_ray;
        logic       set_busy;
        logic       clr_busy;
        logic       div_init;
        logic       div_step;
        logic       cross_write;
        logic       advance;
        logic       imp_mul;
        logic       imp_add;
        logic       emit;
        res_sel_t   res_sel;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic present;
        logic solid;
        logic reject;
        logic busy;
        logic below_limit;
        logic out_free;
    } sts_t;

endpackage

### hw/rtl/vrt_ctrl.sv
// ---------------------------------------------------------------------------
// vrt_ctrl
// Sequencer for ray start, stepping, impact calculation and result issue.
// ---------------------------------------------------------------------------
module vrt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  vrt_pkg::sts_t sts,
    output vrt_pkg::cmd_t cmd
);
    import vrt_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [4:0] bit_reg, bit_next;
    logic       take;

    assign take = item_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
            bit_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (sts.kind == IK_START)
                    begin
                        if (sts.reject)
                            state_next = S_EMIT;
                        else
                        begin
                            state_next = S_DIV;
                            axis_next  = 2'd0;
                            bit_next   = 5'(DIV_BITS - 1);
                        end
                    end
                    else if (sts.busy)
                    begin
                        if (!sts.present)
                            state_next = S_EMIT;
                        else if (sts.solid)
                        begin
                            state_next = S_IMUL;
                            axis_next  = 2'd0;
                        end
                        else
                            state_next = S_CHECK;
                    end
                end
            end
            S_DIV:
            begin
                if (bit_reg == 5'd0)
                    state_next = S_CROSS;
                else
                    bit_next = bit_reg - 5'd1;
            end
            S_CROSS:
            begin
                if (axis_reg == 2'd2)
                    state_next = S_EMIT;
                else
                begin
                    state_next = S_DIV;
                    axis_next  = axis_reg + 2'd1;
                    bit_next   = 5'(DIV_BITS - 1);
                end
            end
            S_CHECK:
            begin
                if (sts.below_limit)
                    state_next = S_EMIT;
                else
                begin
                    state_next = S_IMUL;
                    axis_next  = 2'd0;
                end
            end
            S_IMUL:
                state_next = S_IADD;
            S_IADD:
            begin
                if (axis_reg == 2'd2)
                    state_next = S_EMIT;
                else
                begin
                    state_next = S_IMUL;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.axis   = axis_reg;
        item_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (sts.kind == IK_START)
                    begin
                        cmd.clr_busy = 1'b1;
                        if (sts.reject)
                            cmd.res_sel = RES_REJECT;
                        else
                        begin
                            cmd.load_ray = 1'b1;
                            cmd.set_busy = 1'b1;
                            cmd.div_init = 1'b1;
                            cmd.axis     = 2'd0;
                        end
                    end
                    else if (sts.busy)
                    begin
                        if (!sts.present)
                        begin
                            cmd.clr_busy = 1'b1;
                            cmd.res_sel  = RES_REJECT;
                        end
                        else if (sts.solid)
                        begin
                            cmd.clr_busy = 1'b1;
                            cmd.res_sel  = RES_HIT;
                        end
                        else
                            cmd.advance = 1'b1;
                    end
                end
            end
            S_DIV:
                cmd.div_step = 1'b1;
            S_CROSS:
            begin
                cmd.cross_write = 1'b1;
                cmd.div_init    = 1'b1;
                if (axis_reg == 2'd2)
                    cmd.res_sel = RES_QUERY;
            end
            S_CHECK:
            begin
                if (sts.below_limit)
                    cmd.res_sel = RES_QUERY;
                else
                begin
                    cmd.clr_busy = 1'b1;
                    cmd.res_sel  = RES_MAXD;
                end
            end
            S_IMUL:
                cmd.imp_mul = 1'b1;
            S_IADD:
                cmd.imp_add = 1'b1;
            S_EMIT:
                cmd.emit = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

### hw/rtl/vrt_datapath.sv
// ---------------------------------------------------------------------------
// vrt_datapath
// Ray state, reciprocal divider, crossing and impact arithmetic, result word.
// ---------------------------------------------------------------------------
module vrt_datapath #(
    parameter int unsigned WORLD_HEIGHT = vrt_pkg::WORLD_HEIGHT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  vrt_pkg::item_t  item,
    input  vrt_pkg::cmd_t   cmd,
    output vrt_pkg::sts_t   sts,
    output logic            result_valid,
    input  logic            result_stall,
    output vrt_pkg::result_t result
);
    import vrt_pkg::*;

    localparam logic signed [31:0] Z_TOP = 32'(WORLD_HEIGHT) << 16;

    logic               busy_reg;
    logic [15:0]        voxel_reg [3];
    logic               neg_reg [3];
    logic [31:0]        step_reg [3];
    logic [31:0]        cross_reg [3];
    logic [31:0]        travelled_reg;
    logic [1:0]         last_axis_reg;
    logic [31:0]        origin_reg [3];
    logic signed [15:0] dir_reg [3];
    logic [31:0]        limit_reg;

    logic [15:0]        rem_reg;
    logic [30:0]        quot_reg;
    logic [4:0]         dbit_reg;

    logic signed [48:0] prod_reg;
    result_t            res_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic [15:0]        mag;
    logic [16:0]        trial;
    logic [31:0]        step_val;
    logic [16:0]        frac_dist;
    logic [48:0]        cross_prod;
    logic [31:0]        cross_val;
    logic [1:0]         adv_axis;
    logic [32:0]        adv_sum;
    logic signed [35:0] imp_sum;
    logic [31:0]        imp_val;
    logic [31:0]        imp_dist;
    logic [31:0]        start_s [3];
    logic signed [15:0] start_d [3];

    assign start_s[0] = item.start_x;
    assign start_s[1] = item.start_y;
    assign start_s[2] = item.start_z;
    assign start_d[0] = item.dir_x;
    assign start_d[1] = item.dir_y;
    assign start_d[2] = item.dir_z;

    // The divider works on the magnitude of the axis now being loaded.
    assign mag      = dir_reg[cmd.axis][15] ? 16'(-dir_reg[cmd.axis]) : dir_reg[cmd.axis];
    assign trial    = {rem_reg, (dbit_reg == 5'(DIV_BITS - 1))};
    assign step_val = (mag == 16'd0) ? SAT32 : {1'b0, quot_reg};

    assign frac_dist  = neg_reg[cmd.axis] ? {1'b0, origin_reg[cmd.axis][15:0]}
                                          : 17'h10000 - {1'b0, origin_reg[cmd.axis][15:0]};
    assign cross_prod = 49'(frac_dist) * 49'(step_val);
    assign cross_val  = (cross_prod[48:48] != 1'b0) ? SAT32 : cross_prod[47:16];

    always_comb
    begin
        if (cross_reg[0] < cross_reg[1] && cross_reg[0] < cross_reg[2])
            adv_axis = 2'd0;
        else if (cross_reg[1] < cross_reg[2])
            adv_axis = 2'd1;
        else
            adv_axis = 2'd2;
    end
    assign adv_sum = {1'b0, cross_reg[adv_axis]} + {1'b0, step_reg[adv_axis]};

    // Arithmetic shift gives the floor of the scaled product.
    assign imp_sum = 36'(prod_reg >>> 14) + 36'($signed(origin_reg[cmd.axis]));
    always_comb
    begin
        if (imp_sum > 36'sh0_7FFF_FFFF)
            imp_val = 32'h7FFF_FFFF;
        else if (imp_sum < -36'sh0_8000_0000)
            imp_val = 32'h8000_0000;
        else
            imp_val = imp_sum[31:0];
    end
    assign imp_dist = res_reg.hit_distance;

    assign sts.kind        = item.kind;
    assign sts.present     = item.voxel_present;
    assign sts.solid       = item.voxel_solid;
    assign sts.reject      = (item.start_z < 0) || (item.start_z > Z_TOP)
                             || (item.max_distance == 32'd0);
    assign sts.busy        = busy_reg;
    assign sts.below_limit = travelled_reg < limit_reg;
    assign sts.out_free    = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            travelled_reg <= 32'd0;
            last_axis_reg <= 2'd0;
            limit_reg     <= 32'd0;
            for (int a = 0; a < 3; a++)
            begin
                voxel_reg[a]  <= 16'd0;
                neg_reg[a]    <= 1'b0;
                step_reg[a]   <= 32'd0;
                cross_reg[a]  <= 32'd0;
                origin_reg[a] <= 32'd0;
                dir_reg[a]    <= 16'sd0;
            end
        end
        else
        begin
            if (cmd.clr_busy)
                busy_reg <= 1'b0;
            if (cmd.set_busy)
                busy_reg <= 1'b1;
            if (cmd.load_ray)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    origin_reg[a] <= start_s[a];
                    dir_reg[a]    <= start_d[a];
                    voxel_reg[a]  <= start_s[a][31:16];
                    neg_reg[a]    <= start_d[a][15];
                end
                limit_reg     <= item.max_distance;
                travelled_reg <= 32'd0;
                last_axis_reg <= 2'd0;
            end
            if (cmd.cross_write)
            begin
                step_reg[cmd.axis]  <= step_val;
                cross_reg[cmd.axis] <= cross_val;
            end
            if (cmd.advance)
            begin
                voxel_reg[adv_axis] <= neg_reg[adv_axis] ? voxel_reg[adv_axis] - 16'd1
                                                         : voxel_reg[adv_axis] + 16'd1;
                travelled_reg       <= cross_reg[adv_axis];
                cross_reg[adv_axis] <= adv_sum[32] ? SAT32 : adv_sum[31:0];
                last_axis_reg       <= adv_axis + 2'd1;
            end
        end
    end

    // Restoring division of 2^30 by the magnitude, one quotient bit a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg  <= 16'd0;
            quot_reg <= 31'd0;
            dbit_reg <= 5'(DIV_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            dbit_reg <= dbit_reg - 5'd1;
            if (trial >= {1'b0, mag})
            begin
                rem_reg  <= 16'(trial - {1'b0, mag});
                quot_reg <= {quot_reg[29:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[15:0];
                quot_reg <= {quot_reg[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.imp_mul)
            prod_reg <= dir_reg[cmd.axis] * $signed({1'b0, imp_dist});
        if (cmd.imp_add)
        begin
            case (cmd.axis)
                2'd0:    res_reg.impact_x <= imp_val;
                2'd1:    res_reg.impact_y <= imp_val;
                default: res_reg.impact_z <= imp_val;
            endcase
        end
        case (cmd.res_sel)
            RES_REJECT:
            begin
                res_reg             <= '0;
                res_reg.result_kind <= RK_EXIT;
            end
            RES_QUERY:
            begin
                res_reg             <= '0;
                res_reg.result_kind <= RK_QUERY;
                res_reg.voxel_x     <= voxel_reg[0];
                res_reg.voxel_y     <= voxel_reg[1];
                res_reg.voxel_z     <= voxel_reg[2];
            end
            RES_HIT:
            begin
                res_reg                 <= '0;
                res_reg.result_kind     <= RK_HIT;
                res_reg.voxel_x         <= voxel_reg[0];
                res_reg.voxel_y         <= voxel_reg[1];
                res_reg.voxel_z         <= voxel_reg[2];
                res_reg.hit_distance    <= travelled_reg;
                res_reg.normal_axis     <= last_axis_reg;
                res_reg.normal_negative <= (last_axis_reg != 2'd0)
                                           && !neg_reg[last_axis_reg - 2'd1];
            end
            RES_MAXD:
            begin
                res_reg              <= '0;
                res_reg.result_kind  <= RK_MAXD;
                res_reg.hit_distance <= limit_reg;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_reg <= res_reg;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### hw/rtl/voxel_ray_traversal.sv
// ---------------------------------------------------------------------------
// voxel_ray_traversal
// Amanatides-Woo stepping of a ray through a unit voxel grid.
// ---------------------------------------------------------------------------
// Input channel (item_valid / item_stall / item): a word either starts a ray
// (origin, direction, maximum length) or answers the last voxel query.
// Output channel (result_valid / result_stall / result): one word per item,
// a voxel query, a hit, a max-distance miss or an exit; an answer arriving
// while no ray is in flight gives no word.
// An accepted ray start runs a one-bit-per-cycle reciprocal divider for each
// axis in turn, each followed by a crossing-distance write, before its query
// word is issued. A step answer advances one voxel and compares the distance
// travelled with the limit; a hit, or a max-distance miss found there, then
// computes the impact point on one shared multiplier, one axis at a time, a
// multiply then an add per axis. A rejected start or a missing voxel goes straight to issue.
// One item is worked on at a time; item_stall is high from acceptance until
// the result word is loaded into the output register, which frees the input
// while the word waits on a stalled receiver. A finished word waits for that
// register to empty, so a stalled receiver adds its stall to the latency.
// Reset clears all ray state and the output register is empty.
// ---------------------------------------------------------------------------
module voxel_ray_traversal #(
    parameter int unsigned WORLD_HEIGHT = vrt_pkg::WORLD_HEIGHT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  vrt_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output vrt_pkg::result_t result
);
    import vrt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    vrt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    vrt_datapath #(
        .WORLD_HEIGHT (WORLD_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### hw/rtl/vrt_checker.sv
// ---------------------------------------------------------------------------
// vrt_checker
// Port-level checks on the result words of the voxel ray traversal block.
// ---------------------------------------------------------------------------
module vrt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input vrt_pkg::result_t result
);
    import vrt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    a_query: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == RK_QUERY |->
            result.hit_distance == 32'd0 && result.normal_axis == 2'd0
            && result.impact_x == 32'sd0 && result.impact_z == 32'sd0)
        else $error("query word carries hit fields");

    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == RK_EXIT |->
            result.voxel_x == 16'sd0 && result.voxel_y == 16'sd0
            && result.voxel_z == 16'sd0 && result.hit_distance == 32'd0)
        else $error("exit word not cleared");

    a_maxd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == RK_MAXD |->
            result.normal_axis == 2'd0 && !result.normal_negative
            && result.hit_distance != 32'd0)
        else $error("max-distance word malformed");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (.*);
